/* rtl/dqpi_pkg.sv */
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared widths, register indexes, microcode word and fixed-point helpers
// for the dq current controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dqpi_pkg;

  localparam int NumAxes  = 2;
  localparam int AxisW    = 1;
  localparam int StDepth  = (NumAxes < (1 << AxisW)) ? NumAxes : (1 << AxisW);
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 4;
  localparam int CoefW    = 24;
  localparam int CurW     = 16;
  localparam int StW      = 32;
  localparam int ProdW    = CoefW + StW;
  localparam int AccW     = ProdW + 1;
  localparam int PcW      = 4;

  localparam logic [PcW-1:0] StepNull = PcW'(14);

  typedef enum logic [2:0] {
    CfgFfA = 3'd0,
    CfgFfB = 3'd1,
    CfgFfC = 3'd2,
    CfgFfD = 3'd3,
    CfgFbA = 3'd4,
    CfgFbB = 3'd5,
    CfgFbC = 3'd6,
    CfgFbD = 3'd7
  } coef_idx_e;

  localparam logic signed [CoefW-1:0] CoefOne = CoefW'(1048576);

  typedef enum logic [2:0] {
    OpNone,
    OpXs,
    OpR,
    OpXd,
    OpEd,
    OpXq,
    OpEq
  } op_sel_e;

  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAdd
  } acc_op_e;

  typedef enum logic [2:0] {
    WbNone,
    WbFf,
    WbEq,
    WbXs,
    WbVd,
    WbXd,
    WbVq,
    WbXq
  } wb_e;

  typedef enum logic {
    JmpNone,
    JmpAxisBad
  } jmp_e;

  typedef struct packed {
    coef_idx_e      coef_sel;
    op_sel_e        op_sel;
    acc_op_e        acc_op;
    wb_e            wb;
    jmp_e           jmp;
    logic [PcW-1:0] jmp_tgt;
    logic           last;
    logic           out_zero;
  } ctrl_t;

  function automatic ctrl_t mk(coef_idx_e c, op_sel_e o, acc_op_e a, wb_e w,
                               logic last);
    ctrl_t cw;
    cw.coef_sel = c;
    cw.op_sel   = o;
    cw.acc_op   = a;
    cw.wb       = w;
    cw.jmp      = JmpNone;
    cw.jmp_tgt  = '0;
    cw.last     = last;
    cw.out_zero = 1'b0;
    return cw;
  endfunction

  // Program: the multiply in step n feeds the accumulate in step n+1,
  // whose sum is written back in step n+2.
  function automatic ctrl_t ucode(logic [PcW-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      4'd0: begin
        cw = mk(CfgFfC, OpXs, AccHold, WbNone, 1'b0);
        cw.jmp     = JmpAxisBad;
        cw.jmp_tgt = StepNull;
      end
      4'd1:  cw = mk(CfgFfD, OpR,    AccLoad, WbNone, 1'b0);
      4'd2:  cw = mk(CfgFfA, OpXs,   AccAdd,  WbNone, 1'b0);
      4'd3:  cw = mk(CfgFfB, OpR,    AccLoad, WbFf,   1'b0);
      4'd4:  cw = mk(CfgFbC, OpXd,   AccAdd,  WbEq,   1'b0);
      4'd5:  cw = mk(CfgFbD, OpEd,   AccLoad, WbXs,   1'b0);
      4'd6:  cw = mk(CfgFbA, OpXd,   AccAdd,  WbNone, 1'b0);
      4'd7:  cw = mk(CfgFbB, OpEd,   AccLoad, WbVd,   1'b0);
      4'd8:  cw = mk(CfgFbC, OpXq,   AccAdd,  WbNone, 1'b0);
      4'd9:  cw = mk(CfgFbD, OpEq,   AccLoad, WbXd,   1'b0);
      4'd10: cw = mk(CfgFbA, OpXq,   AccAdd,  WbNone, 1'b0);
      4'd11: cw = mk(CfgFbB, OpEq,   AccLoad, WbVq,   1'b0);
      4'd12: cw = mk(CfgFfA, OpNone, AccAdd,  WbNone, 1'b0);
      4'd13: cw = mk(CfgFfA, OpNone, AccHold, WbXq,   1'b1);
      4'd14: begin
        cw = mk(CfgFfA, OpNone, AccHold, WbNone, 1'b1);
        cw.out_zero = 1'b1;
      end
      default: begin
        cw = mk(CfgFfA, OpNone, AccHold, WbNone, 1'b1);
        cw.out_zero = 1'b1;
      end
    endcase
    return cw;
  endfunction

  // Q.40 -> Q.20, round half up, saturate to 32 bits.
  function automatic logic signed [StW-1:0] rnd_sat_st(logic signed [AccW-1:0] a);
    logic signed [AccW:0]    t;
    logic signed [AccW-20:0] s;
    t = (AccW+1)'(a) + (AccW+1)'(524288);
    s = (AccW-19)'(t >>> 20);
    if (s[AccW-20:StW-1] == {(AccW-18-StW){s[StW-1]}}) begin
      return s[StW-1:0];
    end
    return s[AccW-20] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
  endfunction

  // Q.40 -> Q.12, round half up, saturate to 16 bits.
  function automatic logic signed [CurW-1:0] rnd_sat_v(logic signed [AccW-1:0] a);
    logic signed [AccW:0]    t;
    logic signed [AccW-28:0] s;
    t = (AccW+1)'(a) + (AccW+1)'(134217728);
    s = (AccW-27)'(t >>> 28);
    if (s[AccW-28:CurW-1] == {(AccW-26-CurW){s[CurW-1]}}) begin
      return s[CurW-1:0];
    end
    return s[AccW-28] ? {1'b1, {(CurW-1){1'b0}}} : {1'b0, {(CurW-1){1'b1}}};
  endfunction

  // 33-bit difference saturated to 32 bits.
  function automatic logic signed [StW-1:0] sat_diff(logic signed [StW:0] v);
    if (v[StW] == v[StW-1]) begin
      return v[StW-1:0];
    end
    return v[StW] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

/* rtl/dq_current_pi_state_space.sv */
// ----------------------------------------------------------------------------
// dq_current_pi_state_space
// Per-axis dq current controller with q-reference feedforward shaping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction carries the axis
//   number, the q current reference and the measured d and q currents.
//   Output channel (out_valid_o / out_stall_i): one transaction per input,
//   the saturated d and q voltage references.
//   Config channel (cfg_valid_i / cfg_ready_o): writes one of the eight Q4.20
//   coefficients; indexes eight and above are dropped. Write only while idle.
// Timing:
//   A shared 24x32 multiplier and one accumulator run a 14-step microcode
//   program; a new input is taken only once the program has finished. An axis
//   beyond the configured count jumps from the first step straight to a final
//   step that gives a zero result.
// Reset:
//   Clears all per-axis states, loads the coefficient reset values and empties
//   the output register. No clearing pass is needed.
// Backpressure:
//   The result sits in an output register, so the next input is taken while
//   a result waits; the program only halts on its final step if the previous
//   result has still not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_current_pi_state_space (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dqpi_pkg::AxisW-1:0]          axis_select_i,
  input  logic signed [dqpi_pkg::CurW-1:0]    q_current_target_i,
  input  logic signed [dqpi_pkg::CurW-1:0]    d_current_measured_i,
  input  logic signed [dqpi_pkg::CurW-1:0]    q_current_measured_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dqpi_pkg::CurW-1:0]    d_voltage_command_o,
  output logic signed [dqpi_pkg::CurW-1:0]    q_voltage_command_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dqpi_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dqpi_pkg::CoefW-1:0]          cfg_data_i
);
  import dqpi_pkg::*;

  // Sequencer state
  logic                 busy_q;
  logic [PcW-1:0]       pc_q;
  ctrl_t                ctrl;
  logic                 step_en;
  logic                 axis_ok;
  logic [PcW-1:0]       pc_next;

  // Coefficients and per-axis states
  logic signed [CoefW-1:0] coef_q [NumRegs];
  logic signed [StW-1:0]   xs_q   [StDepth];
  logic signed [StW-1:0]   xd_q   [StDepth];
  logic signed [StW-1:0]   xq_q   [StDepth];

  // Working registers of the current transaction
  logic [AxisW-1:0]        axis_q;
  logic signed [StW-1:0]   r_q, ed_q, iq_q;
  logic signed [StW-1:0]   ff_q, eq_q;
  logic signed [CurW-1:0]  vd_q, vq_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  // Datapath
  logic signed [CoefW-1:0] coef_v;
  logic signed [StW-1:0]   op_v;
  logic signed [StW-1:0]   st_new;
  logic                    in_acc;

  logic signed [StW-1:0]   r_in, id_in, iq_in;

  assign in_stall_o  = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign in_acc      = in_valid_i & ~busy_q;

  assign ctrl    = ucode(pc_q);
  assign axis_ok = (32'(axis_q) < 32'(NumAxes));
  // Hold the final step while the previous result is still waiting.
  assign step_en = busy_q & ~(ctrl.last & out_valid_o & out_stall_i);

  always_comb begin
    if (ctrl.jmp == JmpAxisBad && !axis_ok) begin
      pc_next = ctrl.jmp_tgt;
    end else begin
      pc_next = pc_q + PcW'(1);
    end
  end

  // Scale Q4.12 inputs up to Q.20.
  assign r_in  = {{8{q_current_target_i[CurW-1]}}, q_current_target_i, 8'h00};
  assign id_in = {{8{d_current_measured_i[CurW-1]}}, d_current_measured_i, 8'h00};
  assign iq_in = {{8{q_current_measured_i[CurW-1]}}, q_current_measured_i, 8'h00};

  assign coef_v = coef_q[ctrl.coef_sel];

  always_comb begin
    case (ctrl.op_sel)
      OpXs:    op_v = xs_q[axis_q];
      OpR:     op_v = r_q;
      OpXd:    op_v = xd_q[axis_q];
      OpEd:    op_v = ed_q;
      OpXq:    op_v = xq_q[axis_q];
      OpEq:    op_v = eq_q;
      default: op_v = '0;
    endcase
  end

  assign st_new = rnd_sat_st(acc_q);

  // Control, coefficients, states and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        coef_q[i] <= (i == int'(CfgFfD) || i == int'(CfgFbA)) ? CoefOne : '0;
      end
      for (int i = 0; i < StDepth; i++) begin
        xs_q[i] <= '0;
        xd_q[i] <= '0;
        xq_q[i] <= '0;
      end
    end else begin
      // A finishing step presents its result; otherwise drop a taken one.
      if (step_en && ctrl.last) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (step_en) begin
        if (ctrl.last) begin
          busy_q <= 1'b0;
        end else begin
          pc_q <= pc_next;
        end
      end
      if (cfg_valid_i && cfg_ready_o && (32'(cfg_index_i) < 32'(NumRegs))) begin
        coef_q[cfg_index_i[2:0]] <= cfg_data_i;
      end
      if (step_en && axis_ok) begin
        case (ctrl.wb)
          WbXs:    xs_q[axis_q] <= st_new;
          WbXd:    xd_q[axis_q] <= st_new;
          WbXq:    xq_q[axis_q] <= st_new;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      axis_q <= axis_select_i;
      r_q    <= r_in;
      ed_q   <= -id_in;
      iq_q   <= iq_in;
    end
    if (step_en) begin
      prod_q <= ProdW'(coef_v) * ProdW'(op_v);
      case (ctrl.acc_op)
        AccLoad: acc_q <= AccW'(prod_q);
        AccAdd:  acc_q <= acc_q + AccW'(prod_q);
        default: ;
      endcase
      case (ctrl.wb)
        WbFf:    ff_q <= st_new;
        WbEq:    eq_q <= sat_diff((StW+1)'(ff_q) - (StW+1)'(iq_q));
        WbVd:    vd_q <= rnd_sat_v(acc_q);
        WbVq:    vq_q <= rnd_sat_v(acc_q);
        default: ;
      endcase
      if (ctrl.last) begin
        d_voltage_command_o <= ctrl.out_zero ? '0 : vd_q;
        q_voltage_command_o <= ctrl.out_zero ? '0 : vq_q;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/dqpi_checker.sv */
// ----------------------------------------------------------------------------
// dqpi_checker
// Port-level checks on the dq current controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] d_voltage_command_o,
  input logic signed [15:0] q_voltage_command_o
);

  // An accepted transaction keeps the input side closed (stall high) after the accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("input reopened too early after accept");

  // Finishing a transaction always presents its result.
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("transaction finished without a result");

  // A result never appears while a transaction is still idle-accepted.
  a_no_result_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared right after accept");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(d_voltage_command_o) && $stable(q_voltage_command_o)))
    else $error("stalled result changed");

endmodule

bind dq_current_pi_state_space dqpi_checker u_dqpi_checker (.*);

`default_nettype wire

/* tb/dq_current_pi_state_space_checker.sv */
// ----------------------------------------------------------------------------
// dq_current_pi_state_space_checker
// Watches the sample, result and coefficient channels of the dq current
// controller. Keeps a cycle-free model of the three per-axis states and the
// eight gains, predicts the voltage pair for every accepted sample and checks
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module dq_current_pi_state_space_checker
  import dqpi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [AxisW-1:0]        axis_select_i,
  input  logic signed [CurW-1:0]  q_current_target_i,
  input  logic signed [CurW-1:0]  d_current_measured_i,
  input  logic signed [CurW-1:0]  q_current_measured_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [CurW-1:0]  d_voltage_command_i,
  input  logic signed [CurW-1:0]  q_voltage_command_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CoefW-1:0]        cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CurW-1:0] d_volt;
    logic signed [CurW-1:0] q_volt;
  } volt_pair_t;

  logic signed [CoefW-1:0] gain_q     [NumRegs];
  logic signed [StW-1:0]   shaping_x  [NumAxes];
  logic signed [StW-1:0]   d_loop_x   [NumAxes];
  logic signed [StW-1:0]   q_loop_x   [NumAxes];
  volt_pair_t              volt_cmd_q [$];
  volt_pair_t              oldest_cmd;

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q.40 sums: round half up, then saturate
  function automatic logic signed [StW-1:0] to_q20(longint acc);
    return StW'(clamp((acc + (longint'(1) <<< 19)) >>> 20, StW));
  endfunction

  function automatic logic signed [CurW-1:0] to_q12(longint acc);
    return CurW'(clamp((acc + (longint'(1) <<< 27)) >>> 28, CurW));
  endfunction

  function automatic longint dot2(logic signed [CoefW-1:0] c1, logic signed [StW-1:0] x1,
                                  logic signed [CoefW-1:0] c2, logic signed [StW-1:0] x2);
    return longint'(c1) * longint'(x1) + longint'(c2) * longint'(x2);
  endfunction

  // Run one control step on the selected axis and advance its states.
  function automatic volt_pair_t step_controller(int unsigned ax,
                                                 logic signed [CurW-1:0] iq_target,
                                                 logic signed [CurW-1:0] id_meas,
                                                 logic signed [CurW-1:0] iq_meas);
    volt_pair_t            res;
    logic signed [StW-1:0] target_q20;
    logic signed [StW-1:0] id_q20;
    logic signed [StW-1:0] iq_q20;
    logic signed [StW-1:0] shaped;
    logic signed [StW-1:0] d_err;
    logic signed [StW-1:0] q_err;
    logic signed [StW-1:0] xs;
    logic signed [StW-1:0] xd;
    logic signed [StW-1:0] xq;
    res = '0;
    if (ax >= NumAxes) return res;
    target_q20 = StW'(longint'(iq_target) <<< 8);
    id_q20     = StW'(longint'(id_meas) <<< 8);
    iq_q20     = StW'(longint'(iq_meas) <<< 8);

    xs = shaping_x[ax];
    shaped = to_q20(dot2(gain_q[CfgFfC], xs, gain_q[CfgFfD], target_q20));
    shaping_x[ax] = to_q20(dot2(gain_q[CfgFfA], xs, gain_q[CfgFfB], target_q20));

    d_err = -id_q20;
    q_err = StW'(clamp(longint'(shaped) - longint'(iq_q20), StW));

    xd = d_loop_x[ax];
    res.d_volt = to_q12(dot2(gain_q[CfgFbC], xd, gain_q[CfgFbD], d_err));
    d_loop_x[ax] = to_q20(dot2(gain_q[CfgFbA], xd, gain_q[CfgFbB], d_err));

    xq = q_loop_x[ax];
    res.q_volt = to_q12(dot2(gain_q[CfgFbC], xq, gain_q[CfgFbD], q_err));
    q_loop_x[ax] = to_q20(dot2(gain_q[CfgFbA], xq, gain_q[CfgFbB], q_err));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRegs; k++) gain_q[k] = '0;
      gain_q[CfgFfD] = CoefOne;
      gain_q[CfgFbA] = CoefOne;
      for (int k = 0; k < NumAxes; k++) begin
        shaping_x[k] = '0;
        d_loop_x[k]  = '0;
        q_loop_x[k]  = '0;
      end
      volt_cmd_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // indexes past the last gain are dropped by the block
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NumRegs) begin
        gain_q[cfg_index_i[2:0]] = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        volt_cmd_q.push_back(step_controller(int'(axis_select_i), q_current_target_i,
                                             d_current_measured_i, q_current_measured_i));
        pending_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (volt_cmd_q.size() == 0) begin
          $display("%0t: unexpected result d=%0d q=%0d", $time,
                   d_voltage_command_i, q_voltage_command_i);
          fail_count_o++;
        end else begin
          oldest_cmd = volt_cmd_q.pop_front();
          pending_o--;
          if (oldest_cmd.d_volt !== d_voltage_command_i) begin
            $display("%0t: d_voltage_command expected %0d, got %0d", $time,
                     oldest_cmd.d_volt, d_voltage_command_i);
            fail_count_o++;
          end
          if (oldest_cmd.q_volt !== q_voltage_command_i) begin
            $display("%0t: q_voltage_command expected %0d, got %0d", $time,
                     oldest_cmd.q_volt, q_voltage_command_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

/* tb/dq_current_pi_state_space_test.sv */
// ----------------------------------------------------------------------------
// dq_current_pi_state_space_test
// Drives samples and gain writes into the dq current controller with random
// gaps and output stalls, while the checker beside it predicts and compares
// every voltage pair. Directed cases cover reset gains, half-LSB rounding
// ties, field extremes and all-max / all-min gains; random phases follow.
// ----------------------------------------------------------------------------
module dq_current_pi_state_space_test;

  import dqpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseCount    = 8;
  localparam int PhaseSamples  = 80;
  localparam int DrainCycles   = 20;
  localparam int MaxIdle       = 10;
  localparam int TimeoutNs     = 4_000_000;

  localparam logic [CfgIdxW-1:0] IdxUnusedLo = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] IdxUnusedHi = '1;
  localparam logic [CoefW-1:0]   GainMax     = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic [CoefW-1:0]   GainMin     = {1'b1, {(CoefW-1){1'b0}}};
  localparam logic [CoefW-1:0]   GainHalf    = CoefW'(524288);
  localparam logic [CoefW-1:0]   GainQuarter = CoefW'(262144);
  // small gain that lands state updates exactly on a half LSB for odd inputs
  localparam logic [CoefW-1:0]   GainTie     = CoefW'(6144);
  localparam logic [CurW-1:0]    CurMax      = {1'b0, {(CurW-1){1'b1}}};
  localparam logic [CurW-1:0]    CurMin      = {1'b1, {(CurW-1){1'b0}}};

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [AxisW-1:0]    axis_sel   = '0;
  logic [CurW-1:0]     iq_target  = '0;
  logic [CurW-1:0]     id_meas    = '0;
  logic [CurW-1:0]     iq_meas    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [CurW-1:0]     d_volt;
  logic [CurW-1:0]     q_volt;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CoefW-1:0]    cfg_data   = '0;
  int                  fail_count;
  int                  pending_cmds;

  // idle-free stretches on each side, toggled at random
  bit                  in_calm    = 1'b0;
  bit                  out_calm   = 1'b0;

  always #10 clk_i = ~clk_i;

  dq_current_pi_state_space u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .axis_select_i        (axis_sel),
    .q_current_target_i   (iq_target),
    .d_current_measured_i (id_meas),
    .q_current_measured_i (iq_meas),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .d_voltage_command_o  (d_volt),
    .q_voltage_command_o  (q_volt),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  dq_current_pi_state_space_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .axis_select_i        (axis_sel),
    .q_current_target_i   (iq_target),
    .d_current_measured_i (id_meas),
    .q_current_measured_i (iq_meas),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .d_voltage_command_i  (d_volt),
    .q_voltage_command_i  (q_volt),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .fail_count_o         (fail_count),
    .pending_o            (pending_cmds)
  );

  // Offer one sample transaction after a random gap and hold it until taken.
  // Valid stays high across back-to-back samples, so it is only lowered when
  // a gap follows; this keeps one nonblocking write per signal per edge.
  task automatic push_sample(input logic [AxisW-1:0] ax, input logic [CurW-1:0] tgt,
                             input logic [CurW-1:0] idm, input logic [CurW-1:0] iqm);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    axis_sel  <= ax;
    iq_target <= tgt;
    id_meas   <= idm;
    iq_meas   <= iqm;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Write one gain register and drop valid again once it is taken.
  task automatic write_gain(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_gains(input logic [CoefW-1:0] val);
    for (int k = 0; k < NumRegs; k++) write_gain(CfgIdxW'(k), val);
  endtask

  // Stop offering samples and wait until every predicted result is taken.
  // The first edge lets the checker log the last accepted sample.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_cmds == 0);
    @(posedge clk_i);
  endtask

  // Mix of rails, full-range noise and realistic small currents.
  function automatic logic [CurW-1:0] draw_current();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return CurMax;
    if (pick == 1) return CurMin;
    if (pick < 6) return CurW'($urandom);
    return CurW'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  // Half the gains within +/-1.0 so the loops stay off the rails; some rails,
  // zeros and full-range values to drive saturation.
  function automatic logic [CoefW-1:0] draw_gain();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return GainMax;
    if (pick == 1) return GainMin;
    if (pick == 2) return '0;
    if (pick < 5) return CoefW'($urandom);
    return CoefW'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
  endfunction

  // Result side: draw a stall for every result, then take the next one.
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, MaxIdle);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: feedback output gains are zero, so both commands read zero.
    push_sample(1'b0, CurMax, CurMin, CurMax);
    push_sample(1'b1, CurMin, CurMax, CurMin);
    push_sample(1'b0, 16'd1234, -16'sd567, 16'd89);

    // Gains that hit rounding ties in both the voltage and the state paths;
    // also poke the unused register indexes, which must leave gains alone.
    settle();
    write_gain(CfgIdxW'(CfgFfA), GainHalf);
    write_gain(CfgIdxW'(CfgFfB), GainHalf);
    write_gain(CfgIdxW'(CfgFfC), CoefOne);
    write_gain(CfgIdxW'(CfgFfD), GainQuarter);
    write_gain(CfgIdxW'(CfgFbA), CoefOne);
    write_gain(CfgIdxW'(CfgFbB), GainTie);
    write_gain(CfgIdxW'(CfgFbC), CoefOne);
    write_gain(CfgIdxW'(CfgFbD), GainHalf);
    write_gain(IdxUnusedLo, GainMax);
    write_gain(IdxUnusedHi, GainMin);
    push_sample(1'b0, CurMax, CurMax, CurMax);
    push_sample(1'b0, CurMin, CurMin, CurMin);
    push_sample(1'b1, 16'd0, 16'd1, -16'sd1);
    push_sample(1'b1, 16'd1, -16'sd1, 16'd0);
    push_sample(1'b0, 16'd3, 16'd5, -16'sd7);
    push_sample(1'b1, -16'sd1, 16'd1, CurMin);
    push_sample(1'b0, 16'd0, 16'd0, 16'd0);
    push_sample(1'b1, CurMax, CurMin, 16'd0);
    push_sample(1'b0, CurMin, CurMax, -16'sd1);
    push_sample(1'b1, -16'sd3, 16'd3, -16'sd3);

    // All gains on the positive rail: drive every state into saturation.
    settle();
    write_all_gains(GainMax);
    push_sample(1'b0, CurMax, CurMin, CurMin);
    push_sample(1'b0, CurMax, CurMin, CurMin);
    push_sample(1'b1, CurMin, CurMax, CurMax);
    push_sample(1'b1, CurMin, CurMax, CurMax);
    push_sample(1'b0, 16'd0, 16'd0, 16'd0);

    // All gains on the negative rail.
    settle();
    write_all_gains(GainMin);
    push_sample(1'b1, CurMax, CurMax, CurMin);
    push_sample(1'b1, CurMax, CurMax, CurMin);
    push_sample(1'b0, CurMin, CurMin, CurMax);
    push_sample(1'b0, CurMin, CurMin, CurMax);
    push_sample(1'b1, 16'd0, 16'd0, 16'd0);

    // Random phases: fresh gains each phase, states carry over.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      for (int k = 0; k < NumRegs; k++) write_gain(CfgIdxW'(k), draw_gain());
      write_gain(CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1)), CoefW'($urandom));
      repeat (PhaseSamples) begin
        push_sample(AxisW'($urandom), draw_current(), draw_current(), draw_current());
      end
    end

    // Drain and give the block time to show any stray result.
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_cmds == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dqpi_pkg.sv
rtl/dq_current_pi_state_space.sv
rtl/dqpi_checker.sv
tb/dq_current_pi_state_space_checker.sv
tb/dq_current_pi_state_space_test.sv
